// ----- rtl/core/plbr_pkg.sv -----
// Package for the per-link gap pacing regulator: types and default sizes.
`timescale 1ns / 1ps
package plbr_pkg;

  localparam int unsigned NumLinksDefault   = 16;
  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned BurstDepthDefault = 32;
  localparam int unsigned TagBitsDefault    = 16;
  localparam int unsigned ResultCap         = 32;

  // Register indexes of the configuration port.
  localparam logic [5:0] RegTargetVl  = 6'd0;
  localparam logic [5:0] RegBurstSize = 6'd1;
  localparam logic [5:0] RegMaxQueue  = 6'd2;

  localparam logic KindFrame = 1'b0;
  localparam logic KindTick  = 1'b1;

  localparam logic StatusSent    = 1'b0;
  localparam logic StatusDropped = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StFrameRd,
    StFrame,
    StTickRd,
    StTick,
    StQueueRd,
    StBurst,
    StEmit
  } state_e;

endpackage

// ----- rtl/core/per_link_bag_regulator_with_burst.sv -----
// Top level of the per-link gap pacing regulator with burst accumulation.
`timescale 1ns / 1ps
// Usage: one input channel (in_valid_i / in_stall_o) carries beats that are
// either a frame arrival (kind 0) or one time tick (kind 1). The output
// channel (out_valid_o / out_stall_i) carries one beat per result. last_o
// marks the final result that an input beat causes.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i).
// Per-link state (busy, countdown, queue head and count) lives in one
// synchronous memory, the queued frames in a second, and the held burst
// frames in a third. Each read is registered.
// Beats are handled one at a time, and a beat is accepted only when the
// sequencer is idle. A forwarded frame, or one dropped for a full queue,
// passes StFrameRd, StFrame and StEmit; one for a link out of range passes
// StFrameRd and StEmit, a queued frame StFrameRd and StFrame, and a held
// burst frame StFrameRd. A burst release passes StBurst and StEmit per
// frame. A tick sweeps all NUM_LINKS entries through StTickRd and StTick,
// plus StQueueRd for each link that sends a queued frame. The last tick
// result waits in a hold register until the sweep ends.
// Each result sits in an output register. While the receiver stalls, the
// sequencer waits on the next result. After reset a clearing pass runs
// through all NUM_LINKS link-state entries before the first beat is accepted.
module per_link_bag_regulator_with_burst #(
  parameter int unsigned NUM_LINKS   = plbr_pkg::NumLinksDefault,
  parameter int unsigned QUEUE_DEPTH = plbr_pkg::QueueDepthDefault,
  parameter int unsigned BURST_DEPTH = plbr_pkg::BurstDepthDefault,
  parameter int unsigned TAG_BITS    = plbr_pkg::TagBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  link_i,
  input  logic [15:0] frame_tag_i,
  input  logic [15:0] gap_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_tag_o,
  output logic [3:0]  out_link_o,
  output logic        status_o,
  output logic        last_o
);
  import plbr_pkg::*;

  localparam int unsigned LW  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int unsigned QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW  = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
  localparam int unsigned BCW = $clog2(BURST_DEPTH + 1);
  localparam int unsigned LCW = $clog2(NUM_LINKS + 1);
  localparam int unsigned QAW = LW + QW;
  localparam int unsigned NeedCap = (BURST_DEPTH < ResultCap) ? BURST_DEPTH : ResultCap;

  typedef struct packed {
    logic           busy;
    logic [15:0]    cnt;
    logic [QW-1:0]  head;
    logic [QCW-1:0] qcnt;
  } lstate_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [15:0]         gap;
  } qent_t;

  // Configuration registers.
  logic [4:0] target_q;
  logic [5:0] bsize_q;
  logic [3:0] maxq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 5'd16;
      bsize_q  <= 6'd1;
      maxq_q   <= 4'd8;
    end else if (cfg_we_i) begin
      case ({4'd0, cfg_index_i})
        RegTargetVl:  target_q <= cfg_data_i[4:0];
        RegBurstSize: bsize_q  <= cfg_data_i;
        RegMaxQueue:  maxq_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Memories.
  lstate_t             lmem [NUM_LINKS];
  qent_t               qmem [NUM_LINKS * QUEUE_DEPTH];
  logic [TAG_BITS-1:0] btag [BURST_DEPTH];
  logic [3:0]          blnk [BURST_DEPTH];

  logic          l_we, q_we, b_we;
  logic [LW-1:0] l_wa, l_ra;
  lstate_t       l_wd, l_rd;
  logic [QAW-1:0] q_wa, q_ra;
  qent_t         q_wd, q_rd;
  logic [BW-1:0] b_wa, b_ra;
  logic [TAG_BITS-1:0] b_wtag, b_rtag;
  logic [3:0]    b_wlnk, b_rlnk;

  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_wa] <= l_wd;
    l_rd <= lmem[l_ra];
    if (q_we) qmem[q_wa] <= q_wd;
    q_rd <= qmem[q_ra];
    if (b_we) begin
      btag[b_wa] <= b_wtag;
      blnk[b_wa] <= b_wlnk;
    end
    b_rtag <= btag[b_ra];
    b_rlnk <= blnk[b_ra];
  end

  // Sequencer registers.
  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic [LCW-1:0] clr_q, clr_d;
  logic [LCW-1:0] idx_q, idx_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [BCW-1:0] bi_q, bi_d;
  logic [3:0]     lnk_q, lnk_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [15:0]    gap_q, gap_d;
  lstate_t        ls_q, ls_d;
  logic           ost_q, ost_d, olast_q, olast_d;
  logic           pend_q, pend_d;
  logic [15:0]    ptag_q, ptag_d;
  logic [3:0]     plnk_q, plnk_d;
  logic           ov_q, ov_d;
  logic [15:0]    rtag_q, rtag_d;
  logic [3:0]     rlnk_q, rlnk_d;
  logic           rstat_q, rstat_d, rlast_q, rlast_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      clr_q   <= '0;
      idx_q   <= '0;
      bcnt_q  <= '0;
      bi_q    <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      bcnt_q  <= bcnt_d;
      bi_q    <= bi_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lnk_q   <= lnk_d;
    tag_q   <= tag_d;
    gap_q   <= gap_d;
    ls_q    <= ls_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
    ptag_q  <= ptag_d;
    plnk_q  <= plnk_d;
    rtag_q  <= rtag_d;
    rlnk_q  <= rlnk_d;
    rstat_q <= rstat_d;
    rlast_q <= rlast_d;
  end

  logic clearing;
  assign clearing = (clr_q != LCW'(NUM_LINKS));

  logic in_acc, out_free;
  assign in_stall_o = clearing || (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  logic [BCW-1:0] need, bnext;
  logic [QCW-1:0] lim;
  logic [15:0]    gap_fix;
  logic [LW-1:0]  idx_l;
  logic [15:0]    cdec;
  logic [QW:0]    slot_sum;
  logic [QW-1:0]  slot, head_inc;

  always_comb begin
    // Burst threshold, clamped to one and to the smaller of the store size and ResultCap.
    if (bsize_q == 6'd0) need = BCW'(1);
    else if (32'(bsize_q) > NeedCap) need = BCW'(NeedCap);
    else need = BCW'(bsize_q);
    bnext = (32'(bcnt_q) < BURST_DEPTH) ? bcnt_q + BCW'(1) : bcnt_q;
    if (32'(maxq_q) > QUEUE_DEPTH) lim = QCW'(QUEUE_DEPTH);
    else lim = QCW'(maxq_q);
    gap_fix = (gap_ticks_i == 16'd0) ? 16'd1 : gap_ticks_i;
    idx_l   = idx_q[LW-1:0];
    cdec    = (l_rd.cnt != 16'd0) ? l_rd.cnt - 16'd1 : 16'd0;
    // Queue slots wrap at the queue depth.
    slot_sum = (QW+1)'(ls_q.head) + (QW+1)'(ls_q.qcnt);
    if (32'(slot_sum) >= QUEUE_DEPTH) slot = QW'(slot_sum - (QW+1)'(QUEUE_DEPTH));
    else slot = QW'(slot_sum);
    if (32'(ls_q.head) == QUEUE_DEPTH - 1) head_inc = '0;
    else head_inc = ls_q.head + QW'(1);
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    bcnt_d  = bcnt_q;
    bi_d    = bi_q;
    lnk_d   = lnk_q;
    tag_d   = tag_q;
    gap_d   = gap_q;
    ls_d    = ls_q;
    ost_d   = ost_q;
    olast_d = olast_q;
    pend_d  = pend_q;
    ptag_d  = ptag_q;
    plnk_d  = plnk_q;
    ov_d    = ov_q && out_stall_i;
    rtag_d  = rtag_q;
    rlnk_d  = rlnk_q;
    rstat_d = rstat_q;
    rlast_d = rlast_q;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    b_we = 1'b0; b_wa = bcnt_q[BW-1:0]; b_wtag = tag_q; b_wlnk = lnk_q;
    b_ra = bi_q[BW-1:0];

    if (clearing) begin
      // Clearing pass through the link-state memory.
      l_we  = 1'b1;
      l_wa  = clr_q[LW-1:0];
      clr_d = clr_q + LCW'(1);
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          lnk_d = link_i;
          tag_d = frame_tag_i[TAG_BITS-1:0];
          gap_d = gap_fix;
          if (kind_i == KindTick) begin
            idx_d   = '0;
            state_d = StTickRd;
          end else begin
            l_ra    = LW'(link_i);
            state_d = StFrameRd;
          end
        end
      end
      StFrameRd: begin
        ls_d = l_rd;
        if ({1'b0, lnk_q} == target_q) begin
          // Hold the frame while the store has room; release once enough are held.
          if (32'(bcnt_q) < BURST_DEPTH) b_we = 1'b1;
          bcnt_d = bnext;
          if (bnext >= need) begin
            bi_d = '0; state_d = StBurst;
          end else state_d = StIdle;
        end else if (32'(lnk_q) >= NUM_LINKS) begin
          ost_d = StatusDropped; olast_d = 1'b1; ret_d = StIdle; state_d = StEmit;
        end else state_d = StFrame;
      end
      StFrame: begin
        l_wa    = LW'(lnk_q);
        ret_d   = StIdle;
        olast_d = 1'b1;
        if (!ls_q.busy) begin
          l_we = 1'b1;
          l_wd = ls_q; l_wd.busy = 1'b1; l_wd.cnt = gap_q;
          ost_d = StatusSent; state_d = StEmit;
        end else if (ls_q.qcnt >= lim) begin
          ost_d = StatusDropped; state_d = StEmit;
        end else begin
          l_we = 1'b1;
          l_wd = ls_q; l_wd.qcnt = ls_q.qcnt + QCW'(1);
          q_we = 1'b1;
          q_wa = {LW'(lnk_q), slot};
          q_wd.tag = tag_q; q_wd.gap = gap_q;
          state_d = StIdle;
        end
      end
      StBurst: begin
        // Read one held frame; it is sent from StEmit.
        ret_d = StBurst;
        ost_d = StatusSent;
        if (bi_q == bcnt_q) begin
          bcnt_d = '0; bi_d = '0; state_d = StIdle;
        end else begin
          olast_d = (bi_q + BCW'(1) == bcnt_q);
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          ov_d    = 1'b1;
          rstat_d = ost_q;
          rlast_d = olast_q;
          if (ret_q == StBurst) begin
            rtag_d = 16'(b_rtag); rlnk_d = b_rlnk;
            bi_d   = bi_q + BCW'(1);
          end else begin
            rtag_d = 16'(tag_q); rlnk_d = lnk_q;
          end
          state_d = ret_q;
        end
      end
      StTickRd: begin
        if (idx_q == LCW'(NUM_LINKS)) begin
          // End of the sweep: the held result is the final one.
          if (!pend_q) begin
            state_d = StIdle;
          end else if (out_free) begin
            ov_d = 1'b1;
            rtag_d = ptag_q; rlnk_d = plnk_q; rstat_d = StatusSent; rlast_d = 1'b1;
            pend_d = 1'b0;
            state_d = StIdle;
          end
        end else begin
          l_ra = idx_l;
          state_d = StTick;
        end
      end
      StTick: begin
        l_wa = idx_l;
        ls_d = l_rd;
        if (!l_rd.busy) begin
          idx_d = idx_q + LCW'(1); state_d = StTickRd;
        end else if (cdec != 16'd0) begin
          l_we = 1'b1; l_wd = l_rd; l_wd.cnt = cdec;
          idx_d = idx_q + LCW'(1); state_d = StTickRd;
        end else if (l_rd.qcnt == '0) begin
          l_we = 1'b1; l_wd = l_rd; l_wd.busy = 1'b0; l_wd.cnt = 16'd0;
          idx_d = idx_q + LCW'(1); state_d = StTickRd;
        end else begin
          q_ra = {idx_l, l_rd.head};
          state_d = StQueueRd;
        end
      end
      StQueueRd: begin
        // Send the head frame; any earlier tick result leaves the hold first.
        q_ra = {idx_l, ls_q.head};
        if (!pend_q || out_free) begin
          if (pend_q) begin
            ov_d = 1'b1;
            rtag_d = ptag_q; rlnk_d = plnk_q; rstat_d = StatusSent; rlast_d = 1'b0;
          end
          pend_d = 1'b1;
          ptag_d = 16'(q_rd.tag);
          plnk_d = 4'(idx_q);
          l_we = 1'b1; l_wa = idx_l; l_wd = ls_q;
          l_wd.head = head_inc;
          l_wd.qcnt = ls_q.qcnt - QCW'(1);
          l_wd.cnt  = q_rd.gap;
          idx_d = idx_q + LCW'(1);
          state_d = StTickRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_tag_o   = rtag_q;
  assign out_link_o  = rlnk_q;
  assign status_o    = rstat_q;
  assign last_o      = rlast_q;

  // Assertions.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_acc) else $error("beat accepted during clearing pass");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == StIdle) else $error("beat accepted while busy");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bcnt_q) <= BURST_DEPTH) else $error("burst count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(rtag_q) && $stable(rlnk_q) &&
    $stable(rstat_q) && $stable(rlast_q))) else $error("stalled result changed");

endmodule
